@@ rtl/core/lsrt_pkg.sv @@
`default_nettype none

package lsrt_pkg;

    localparam int NUM_REGS = 12;
    localparam int PTR_W    = $clog2(NUM_REGS);

    // Bus and timer commands carried by one input item.
    typedef enum logic [2:0] {
        CMD_WR_START = 3'd0,
        CMD_WR_BYTE  = 3'd1,
        CMD_RD_START = 3'd2,
        CMD_RD_NEXT  = 3'd3,
        CMD_TICK     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ACC_OK       = 2'd0,
        ACC_READ_ONLY = 2'd1,
        ACC_BAD_CODE = 2'd2
    } acc_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SESSION = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_DELAY   = 2'd2;

    // Register map.
    localparam logic [PTR_W-1:0] ADDR_WHO      = PTR_W'(0);
    localparam logic [PTR_W-1:0] ADDR_CTRL     = PTR_W'(1);
    localparam logic [PTR_W-1:0] ADDR_STAT     = PTR_W'(2);
    localparam logic [PTR_W-1:0] ADDR_TEMP_LO  = PTR_W'(3);
    localparam logic [PTR_W-1:0] ADDR_TEMP_HI  = PTR_W'(4);
    localparam logic [PTR_W-1:0] ADDR_HUM_LO   = PTR_W'(5);
    localparam logic [PTR_W-1:0] ADDR_HUM_HI   = PTR_W'(6);
    localparam logic [PTR_W-1:0] ADDR_CONFIG   = PTR_W'(7);
    localparam logic [PTR_W-1:0] ADDR_SPARE    = PTR_W'(8);
    localparam logic [PTR_W-1:0] ADDR_SESSION  = PTR_W'(9);
    localparam logic [PTR_W-1:0] ADDR_KEY      = PTR_W'(10);
    localparam logic [PTR_W-1:0] ADDR_LOCKSTAT = PTR_W'(11);

    localparam logic [7:0]  WHO_AM_I_VALUE  = 8'h42;
    localparam logic [15:0] DATA_LOCKED     = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
    localparam logic [15:0] DELAY_RESET     = 16'd500;
    localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  data_byte;
        logic [15:0] temp_sample;
        logic [15:0] humid_sample;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] access_status;
        logic       is_locked;
    } result_t;

    typedef struct packed {
        logic        wr;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

    // Byte modulo 12 by reciprocal: floor(b / 12) == (b * 171) >> 11 for any byte.
    function automatic logic [PTR_W-1:0] byte_mod_regs(input logic [7:0] b);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        prod = 16'(b) * 16'd171;
        quot = prod[15:11];
        rem  = b - 8'(quot) * 8'd12;
        return rem[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(NUM_REGS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lsrt_regs.sv @@
`default_nettype none

module lsrt_regs (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lsrt_pkg::cfg_wr_t cfg,
    input  wire logic             step,
    input  wire lsrt_pkg::item_t  item,
    output lsrt_pkg::result_t     result
);
    import lsrt_pkg::*;

    logic [7:0]       session_reg;
    logic [15:0]      timeout_reg;
    logic [15:0]      delay_reg;

    logic [7:0]       ctrl1_reg,     ctrl1_next;
    logic [7:0]       config_reg,    config_next;
    logic [7:0]       spare_reg,     spare_next;
    logic [7:0]       unlock_reg,    unlock_next;
    logic [15:0]      temp_reg,      temp_next;
    logic [15:0]      humid_reg,     humid_next;
    logic             locked_reg,    locked_next;
    logic             ready_reg,     ready_next;
    logic [PTR_W-1:0] ptr_reg,       ptr_next;
    logic             addr_seen_reg, addr_seen_next;
    logic             measuring_reg, measuring_next;
    logic [15:0]      meas_el_reg,   meas_el_next;
    logic [15:0]      unl_el_reg,    unl_el_next;

    logic [PTR_W-1:0] rd_idx;
    logic [7:0]       rd_byte;
    logic [15:0]      meas_inc;

    always_comb begin
        case (rd_idx)
            ADDR_WHO:      rd_byte = WHO_AM_I_VALUE;
            ADDR_CTRL:     rd_byte = ctrl1_reg;
            ADDR_STAT:     rd_byte = {6'd0, locked_reg, ready_reg};
            ADDR_TEMP_LO:  rd_byte = temp_reg[7:0];
            ADDR_TEMP_HI:  rd_byte = temp_reg[15:8];
            ADDR_HUM_LO:   rd_byte = humid_reg[7:0];
            ADDR_HUM_HI:   rd_byte = humid_reg[15:8];
            ADDR_CONFIG:   rd_byte = config_reg;
            ADDR_SPARE:    rd_byte = spare_reg;
            ADDR_SESSION:  rd_byte = session_reg;
            ADDR_KEY:      rd_byte = unlock_reg;
            ADDR_LOCKSTAT: rd_byte = {7'd0, locked_reg};
            default:       rd_byte = 8'd0;
        endcase
    end

    always_comb begin
        ctrl1_next     = ctrl1_reg;
        config_next    = config_reg;
        spare_next     = spare_reg;
        unlock_next    = unlock_reg;
        temp_next      = temp_reg;
        humid_next     = humid_reg;
        locked_next    = locked_reg;
        ready_next     = ready_reg;
        ptr_next       = ptr_reg;
        addr_seen_next = addr_seen_reg;
        measuring_next = measuring_reg;
        meas_el_next   = meas_el_reg;
        unl_el_next    = unl_el_reg;
        rd_idx         = ptr_reg;
        meas_inc       = meas_el_reg;
        result         = '0;

        case (item.command)
            CMD_WR_START: begin
                addr_seen_next = 1'b0;
            end
            CMD_WR_BYTE: begin
                if (!addr_seen_reg) begin
                    ptr_next       = byte_mod_regs(item.data_byte);
                    addr_seen_next = 1'b1;
                end else begin
                    case (ptr_reg)
                        ADDR_CTRL: begin
                            ctrl1_next = item.data_byte;
                            if (item.data_byte[0] && !locked_reg && !measuring_reg) begin
                                measuring_next = 1'b1;
                                meas_el_next   = '0;
                                ready_next     = 1'b0;
                            end
                        end
                        ADDR_CONFIG: config_next = item.data_byte;
                        ADDR_SPARE:  spare_next  = item.data_byte;
                        ADDR_KEY: begin
                            unlock_next = item.data_byte;
                            if (item.data_byte == session_reg) begin
                                locked_next = 1'b0;
                                unl_el_next = '0;
                            end else begin
                                result.access_status = ACC_BAD_CODE;
                            end
                        end
                        default: result.access_status = ACC_READ_ONLY;
                    endcase
                    ptr_next = ptr_inc(ptr_reg);
                end
            end
            CMD_RD_START: begin
                result.read_data = rd_byte;
            end
            CMD_RD_NEXT: begin
                rd_idx           = ptr_inc(ptr_reg);
                ptr_next         = rd_idx;
                result.read_data = rd_byte;
            end
            CMD_TICK: begin
                // The relock check runs first, so a relock cancels a pending measurement.
                if (!locked_reg) begin
                    if (unl_el_reg >= timeout_reg) begin
                        locked_next    = 1'b1;
                        ready_next     = 1'b0;
                        temp_next      = DATA_LOCKED;
                        humid_next     = DATA_LOCKED;
                        measuring_next = 1'b0;
                    end else begin
                        unl_el_next = unl_el_reg + 16'd1;
                    end
                end
                if (measuring_next) begin
                    meas_inc     = (meas_el_reg != ELAPSED_MAX) ? meas_el_reg + 16'd1
                                                                 : meas_el_reg;
                    meas_el_next = meas_inc;
                    if (meas_inc >= delay_reg) begin
                        temp_next      = item.temp_sample;
                        humid_next     = item.humid_sample;
                        ready_next     = 1'b1;
                        measuring_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        result.is_locked = locked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg   <= 8'd0;
            timeout_reg   <= TIMEOUT_RESET;
            delay_reg     <= DELAY_RESET;
            ctrl1_reg     <= 8'd0;
            config_reg    <= 8'd0;
            spare_reg     <= 8'd0;
            unlock_reg    <= 8'd0;
            temp_reg      <= DATA_LOCKED;
            humid_reg     <= DATA_LOCKED;
            locked_reg    <= 1'b1;
            ready_reg     <= 1'b0;
            ptr_reg       <= '0;
            addr_seen_reg <= 1'b0;
            measuring_reg <= 1'b0;
            meas_el_reg   <= '0;
            unl_el_reg    <= '0;
        end else begin
            if (cfg.wr) begin
                case (cfg.index)
                    CFG_SESSION: session_reg <= cfg.data[7:0];
                    CFG_TIMEOUT: timeout_reg <= cfg.data;
                    CFG_DELAY:   delay_reg   <= cfg.data;
                    default: ;
                endcase
            end
            if (step) begin
                ctrl1_reg     <= ctrl1_next;
                config_reg    <= config_next;
                spare_reg     <= spare_next;
                unlock_reg    <= unlock_next;
                temp_reg      <= temp_next;
                humid_reg     <= humid_next;
                locked_reg    <= locked_next;
                ready_reg     <= ready_next;
                ptr_reg       <= ptr_next;
                addr_seen_reg <= addr_seen_next;
                measuring_reg <= measuring_next;
                meas_el_reg   <= meas_el_next;
                unl_el_reg    <= unl_el_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/locked_sensor_register_target_unit.sv @@
// Locked sensor register target: a twelve-register byte-bus target with an unlock
// session and a timed measurement.
// Input channel (s_valid/s_ready): one item is a bus command (write start, write
// byte, read start, read next) or a timer tick, with the sensor samples.
// Result channel (m_valid/m_ready): exactly one result item per input item, in
// order, giving the read byte, the access status and the lock state afterwards.
// Configuration channel (cfg_valid/cfg_ready): always ready; index 0 session code,
// 1 lock timeout in ticks, 2 measurement delay in ticks. Write it only while idle.
// An accepted item is held in an input register, processed combinationally and
// written into the result register as it moves on, which a stalled receiver can
// delay. Throughput is one item per cycle while the receiver does not stall, set
// by the register update between the input and result registers.
// When the receiver stalls, the result is held and the input register still takes
// one more item; s_ready then falls until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers, relocks the device,
// restores the register map and sets the timeout to 5000 and the delay to 500.
`default_nettype none

module locked_sensor_register_target_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [15:0] s_temp_sample,
    input  wire logic [15:0] s_humid_sample,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic [1:0]       m_access_status,
    output logic             m_is_locked,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import lsrt_pkg::*;

    logic    in_vld_reg;
    item_t   in_item_reg;
    logic    out_vld_reg;
    result_t out_res_reg;
    result_t step_res;
    cfg_wr_t cfg_wr;
    logic    advance;

    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = '{wr: cfg_valid, index: cfg_index, data: cfg_data};

    lsrt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_wr),
        .step    (advance),
        .item    (in_item_reg),
        .result  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_item_reg <= '{command: s_command, data_byte: s_data_byte,
                             temp_sample: s_temp_sample, humid_sample: s_humid_sample};
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_read_data     = out_res_reg.read_data;
    assign m_access_status = out_res_reg.access_status;
    assign m_is_locked     = out_res_reg.is_locked;

    // Input is refused only when both registers are full and the result is stalled.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("s_ready low while a register is free");

    // A held item in the input stage stays until it moves on.
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_item_reg)))
        else $error("input item lost while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_access_status == ACC_OK || m_access_status == ACC_READ_ONLY
                     || m_access_status == ACC_BAD_CODE))
        else $error("invalid access status");

    // A stalled result is not overwritten.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> (out_vld_reg && $stable(out_res_reg)))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ verif/locked_sensor_register_target_unit_tb.sv @@
`timescale 1ns / 100ps

import lsrt_pkg::*;

class register_target_mirror;
    localparam logic [7:0] LOCK_ON    = 8'd1;
    localparam logic [7:0] LOCK_OFF   = 8'd0;
    localparam int         READY_BIT  = 0;
    localparam int         LOCKED_BIT = 1;

    logic [7:0]       regs [NUM_REGS];
    logic [PTR_W-1:0] ptr;
    bit               addr_seen;
    bit               measuring;
    logic [15:0]      meas_cnt;
    logic [15:0]      unlock_cnt;
    logic [7:0]       code;
    logic [15:0]      timeout;
    logic [15:0]      delay;

    result_t expected_results [$];
    int      errors;
    int      checked;

    function new();
        code    = 8'd0;
        timeout = TIMEOUT_RESET;
        delay   = DELAY_RESET;
        foreach (regs[i]) regs[i] = 8'd0;
        regs[ADDR_WHO]              = WHO_AM_I_VALUE;
        regs[ADDR_STAT]             = 8'd0;
        regs[ADDR_STAT][LOCKED_BIT] = 1'b1;
        regs[ADDR_TEMP_LO]          = DATA_LOCKED[7:0];
        regs[ADDR_TEMP_HI]          = DATA_LOCKED[15:8];
        regs[ADDR_HUM_LO]           = DATA_LOCKED[7:0];
        regs[ADDR_HUM_HI]           = DATA_LOCKED[15:8];
        regs[ADDR_SESSION]          = code;
        regs[ADDR_LOCKSTAT]         = LOCK_ON;
        ptr        = '0;
        addr_seen  = 1'b0;
        measuring  = 1'b0;
        meas_cnt   = '0;
        unlock_cnt = '0;
        errors     = 0;
        checked    = 0;
    endfunction

    function void set_config(logic [1:0] index, logic [15:0] data);
        case (index)
            CFG_SESSION: begin
                code               = data[7:0];
                regs[ADDR_SESSION] = data[7:0];
            end
            CFG_TIMEOUT: timeout = data;
            CFG_DELAY:   delay   = data;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function bit locked();
        return regs[ADDR_LOCKSTAT] == LOCK_ON;
    endfunction

    function bit read_only(logic [PTR_W-1:0] r);
        case (r)
            ADDR_WHO, ADDR_STAT, ADDR_TEMP_LO, ADDR_TEMP_HI, ADDR_HUM_LO, ADDR_HUM_HI,
            ADDR_SESSION, ADDR_LOCKSTAT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
        return (p == PTR_W'(NUM_REGS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Updates the mirrored register file and returns the response to one item.
    function result_t predict_response(item_t it);
        result_t          r;
        logic [PTR_W-1:0] p;
        r = '0;
        p = ptr;
        case (it.command)
            CMD_WR_START: addr_seen = 1'b0;
            CMD_WR_BYTE: begin
                if (!addr_seen) begin
                    p         = PTR_W'(it.data_byte % NUM_REGS);
                    addr_seen = 1'b1;
                end else begin
                    if (read_only(p)) begin
                        r.access_status = ACC_READ_ONLY;
                    end else begin
                        regs[p] = it.data_byte;
                        if (p == ADDR_CTRL && it.data_byte[0] && !locked() && !measuring) begin
                            measuring                  = 1'b1;
                            meas_cnt                   = '0;
                            regs[ADDR_STAT][READY_BIT] = 1'b0;
                        end
                        if (p == ADDR_KEY) begin
                            if (it.data_byte == regs[ADDR_SESSION]) begin
                                regs[ADDR_LOCKSTAT]         = LOCK_OFF;
                                regs[ADDR_STAT][LOCKED_BIT] = 1'b0;
                                unlock_cnt                  = '0;
                            end else begin
                                r.access_status = ACC_BAD_CODE;
                            end
                        end
                    end
                    p = advance(p);
                end
            end
            CMD_RD_START: r.read_data = regs[p];
            CMD_RD_NEXT: begin
                p           = advance(p);
                r.read_data = regs[p];
            end
            CMD_TICK: begin
                // The relock check is made before the measurement counts on.
                if (!locked()) begin
                    if (unlock_cnt >= timeout) begin
                        regs[ADDR_LOCKSTAT]         = LOCK_ON;
                        regs[ADDR_STAT][LOCKED_BIT] = 1'b1;
                        regs[ADDR_STAT][READY_BIT]  = 1'b0;
                        regs[ADDR_TEMP_LO]          = DATA_LOCKED[7:0];
                        regs[ADDR_TEMP_HI]          = DATA_LOCKED[15:8];
                        regs[ADDR_HUM_LO]           = DATA_LOCKED[7:0];
                        regs[ADDR_HUM_HI]           = DATA_LOCKED[15:8];
                        measuring                   = 1'b0;
                    end else begin
                        unlock_cnt = unlock_cnt + 16'd1;
                    end
                end
                if (measuring) begin
                    if (meas_cnt != ELAPSED_MAX) meas_cnt = meas_cnt + 16'd1;
                    if (meas_cnt >= delay) begin
                        regs[ADDR_TEMP_LO]         = it.temp_sample[7:0];
                        regs[ADDR_TEMP_HI]         = it.temp_sample[15:8];
                        regs[ADDR_HUM_LO]          = it.humid_sample[7:0];
                        regs[ADDR_HUM_HI]          = it.humid_sample[15:8];
                        regs[ADDR_STAT][READY_BIT] = 1'b1;
                        measuring                  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        ptr         = p;
        r.is_locked = locked();
        return r;
    endfunction

    function void note_item(item_t it);
        expected_results.push_back(predict_response(it));
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected: read_data %h, status %0d, locked %0d",
                     $time, got.read_data, got.access_status, got.is_locked);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.read_data, got.read_data);
            errors++;
        end
        if (got.access_status !== want.access_status) begin
            $display("%0t: access_status mismatch: expected %0d, actual %0d",
                     $time, want.access_status, got.access_status);
            errors++;
        end
        if (got.is_locked !== want.is_locked) begin
            $display("%0t: is_locked mismatch: expected %0d, actual %0d",
                     $time, want.is_locked, got.is_locked);
            errors++;
        end
    endfunction
endclass

module locked_sensor_register_target_unit_tb;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command      = '0;
    logic [7:0]  s_data_byte    = '0;
    logic [15:0] s_temp_sample  = '0;
    logic [15:0] s_humid_sample = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_read_data;
    logic [1:0]  m_access_status;
    logic        m_is_locked;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = '0;
    logic [15:0] cfg_data       = '0;

    register_target_mirror board;

    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         sent_items    = 0;
    int         settings      = 0;
    int         hold_requests = 0;
    int         hold_served   = 0;
    int         hold_left     = 0;
    logic [7:0] cur_code      = 8'd0;

    locked_sensor_register_target_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .s_temp_sample   (s_temp_sample),
        .s_humid_sample  (s_humid_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_access_status (m_access_status),
        .m_is_locked     (m_is_locked),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        #200000;
        $display("** locked_sensor_register_target_unit: FAILED **");
        $finish;
    end

    // Receiver: checks results and stalls at random or for a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                board.check_result('{m_read_data, m_access_status, m_is_locked});
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = 64;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic offer_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= it.command;
        s_data_byte    <= it.data_byte;
        s_temp_sample  <= it.temp_sample;
        s_humid_sample <= it.humid_sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(it);
        sent_items++;
    endtask

    task automatic offer(input logic [2:0] cmd, input logic [7:0] data);
        offer_item('{cmd, data, 16'($urandom), 16'($urandom)});
    endtask

    // Waits until every result is in, with the block's pipeline drained.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_config(index, data);
        if (index == CFG_SESSION) cur_code = data[7:0];
        settings++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // An address byte for a register, often with a multiple of twelve added on.
    function automatic logic [7:0] addr_byte(input logic [PTR_W-1:0] r);
        return 8'(r) + 8'(12 * $urandom_range(0, 20));
    endfunction

    task automatic run_sequence();
        int kind;
        kind = $urandom_range(99);
        if (kind < 18) begin
            offer(CMD_WR_START, 8'($urandom));
            offer(CMD_WR_BYTE, addr_byte(ADDR_KEY));
            if ($urandom_range(9) < 8) begin
                offer(CMD_WR_BYTE, cur_code);
            end else begin
                offer(CMD_WR_BYTE, cur_code + 8'($urandom_range(1, 255)));
            end
        end else if (kind < 33) begin
            offer(CMD_WR_START, 8'($urandom));
            offer(CMD_WR_BYTE, addr_byte(ADDR_CTRL));
            offer(CMD_WR_BYTE, {7'($urandom), ($urandom_range(4) != 0)});
        end else if (kind < 55) begin
            repeat ($urandom_range(1, 8)) offer(CMD_TICK, 8'($urandom));
        end else if (kind < 72) begin
            if ($urandom_range(1)) begin
                offer(CMD_WR_START, 8'($urandom));
                offer(CMD_WR_BYTE, 8'($urandom));
            end
            offer(CMD_RD_START, 8'($urandom));
            repeat ($urandom_range(1, 12)) offer(CMD_RD_NEXT, 8'($urandom));
        end else if (kind < 87) begin
            offer(CMD_WR_START, 8'($urandom));
            offer(CMD_WR_BYTE, 8'($urandom));
            repeat ($urandom_range(1, 6)) offer(CMD_WR_BYTE, 8'($urandom));
        end else begin
            // Noise, including the unused command codes.
            repeat ($urandom_range(1, 4)) offer(3'($urandom_range(7)), 8'($urandom));
        end
    endtask

    initial begin
        int phase_end;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset map and defaults: read-only write, wrong code, unlock, measurement start.
        offer(CMD_RD_START, 8'h00);
        offer(CMD_RD_NEXT, 8'hFF);
        offer(CMD_WR_START, 8'h00);
        offer(CMD_WR_BYTE, 8'hFF);
        offer(CMD_WR_BYTE, 8'h55);
        offer(CMD_WR_START, 8'h00);
        offer(CMD_WR_BYTE, 8'(ADDR_KEY));
        offer(CMD_WR_BYTE, 8'h01);
        offer(CMD_WR_START, 8'h00);
        offer(CMD_WR_BYTE, 8'(ADDR_KEY));
        offer(CMD_WR_BYTE, 8'h00);
        offer(CMD_WR_START, 8'h00);
        offer(CMD_WR_BYTE, 8'(ADDR_CTRL));
        offer(CMD_WR_BYTE, 8'h01);
        offer_item('{3'd7, 8'hFF, 16'hFFFF, 16'hFFFF});
        offer(CMD_TICK, 8'h00);
        settle();

        // Short timers: a second start while measuring, completion, then relock.
        write_setting(CFG_TIMEOUT, 16'd3);
        write_setting(CFG_DELAY, 16'd1);
        offer(CMD_WR_START, 8'h00);
        offer(CMD_WR_BYTE, 8'(ADDR_CTRL));
        offer(CMD_WR_BYTE, 8'hFF);
        offer_item('{CMD_TICK, 8'h00, 16'hFFFF, 16'h0000});
        offer(CMD_RD_START, 8'h00);
        offer(CMD_RD_NEXT, 8'h00);
        offer_item('{CMD_TICK, 8'hFF, 16'h0000, 16'hFFFF});
        offer(CMD_TICK, 8'h00);
        offer(CMD_RD_START, 8'h00);

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_setting(CFG_SESSION, 16'h3CA5);
                    write_setting(CFG_TIMEOUT, 16'd6);
                    write_setting(CFG_DELAY, 16'd2);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    write_setting(CFG_SESSION, {8'($urandom), 8'hFF});
                    write_setting(CFG_TIMEOUT, 16'd0);
                    write_setting(CFG_DELAY, 16'd0);
                    send_idle_pct = 73;
                    stall_pct     = 0;
                end
                2: begin
                    write_setting(CFG_SESSION, 16'($urandom));
                    write_setting(CFG_TIMEOUT, 16'hFFFF);
                    write_setting(CFG_DELAY, 16'd1);
                    send_idle_pct = 0;
                    stall_pct     = 73;
                end
                3: begin
                    write_setting(CFG_SESSION, 16'($urandom));
                    write_setting(CFG_TIMEOUT, 16'($urandom_range(2, 12)));
                    write_setting(CFG_DELAY, 16'hFFFF);
                    send_idle_pct = 7;
                    stall_pct     = 7;
                end
                default: begin
                    write_setting(CFG_SESSION, 16'h0000);
                    write_setting(CFG_TIMEOUT, 16'd20);
                    write_setting(CFG_DELAY, 16'd5);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    // The receiver holds off while items keep coming, so the block backs up.
                    hold_requests++;
                end
            endcase
            phase_end = sent_items + 90;
            while (sent_items < phase_end) run_sequence();
        end
        settle();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d items and %0d results under %0d register settings,",
                 sent_items, board.checked, settings);
        $display("with unlock sessions, measurements, relocks, sweeps, stalls and a hold-off.");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("** locked_sensor_register_target_unit: PASSED **");
        end else begin
            $display("** locked_sensor_register_target_unit: FAILED **");
        end
        $finish;
    end

endmodule
